[hdl/fbc_pkg.sv]
`default_nettype none
package fbc_pkg;

  localparam int FIELD_W     = 32;
  localparam int OP_W        = 2;
  localparam int SLOT_W      = 3;
  localparam int NUM_PLANES  = 6;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_VALS    = 6;
  localparam int DEF_COORD_W = 32;
  localparam int DEF_FRAC_W  = 16;

  localparam logic [OP_W-1:0] OP_PLANE  = 2'd0;
  localparam logic [OP_W-1:0] OP_CORNER = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    K_PLANE  = 2'd0,
    K_CORNER = 2'd1,
    K_TEST   = 2'd2
  } kind_t;

endpackage
`default_nettype wire

[hdl/frustum_box_cull.sv]
`default_nettype none
// Frustum culling for axis-aligned boxes. Software first loads the six
// frustum planes (op 0, slot 0 to 5, a b c d) and the eight frustum corners
// (op 1, slot 0 to 7, x y z); a box test (op 2) then returns one transfer
// with visible set unless some plane has every box corner strictly on its
// negative side, or all frustum corners lie strictly beyond one face of the
// box. Loads return nothing, and op 3 or a plane slot of six or seven is
// dropped. A load is written into its store when the back end takes it from
// the queue. A test is taken from the queue, then runs the six planes, one
// plane per cycle, through the three 32 by 32 multipliers (only the box
// corner that maximises the plane sum is evaluated), then does the
// corner-versus-face compares one axis at a time, and then hands the verdict
// to the result register, which it holds for as long as an earlier result is still
// waiting there. A two-entry queue sits between the accepting front end and
// the evaluating back end, so requests keep arriving while a test is in
// flight, and the next test can run its plane and face checks while the
// previous result waits to be taken.
module frustum_box_cull #(
  parameter int COORD_WIDTH = fbc_pkg::DEF_COORD_W,
  parameter int FRAC_BITS   = fbc_pkg::DEF_FRAC_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [fbc_pkg::OP_W-1:0]         op,
  input  wire logic [fbc_pkg::SLOT_W-1:0]       slot,
  input  wire logic [fbc_pkg::FIELD_W-1:0]      coef_a,
  input  wire logic [fbc_pkg::FIELD_W-1:0]      coef_b,
  input  wire logic [fbc_pkg::FIELD_W-1:0]      coef_c,
  input  wire logic [fbc_pkg::FIELD_W-1:0]      coef_d,
  input  wire logic [fbc_pkg::FIELD_W-1:0]      min_x,
  input  wire logic [fbc_pkg::FIELD_W-1:0]      min_y,
  input  wire logic [fbc_pkg::FIELD_W-1:0]      min_z,
  input  wire logic [fbc_pkg::FIELD_W-1:0]      max_x,
  input  wire logic [fbc_pkg::FIELD_W-1:0]      max_y,
  input  wire logic [fbc_pkg::FIELD_W-1:0]      max_z,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic                                  visible
);
  import fbc_pkg::*;

  // Queue entry: kind, slot and six values of the working width.
  localparam int QW = 2 + SLOT_W + NUM_VALS * COORD_WIDTH;

  logic                                    q_push;
  logic                                    q_pop;
  logic                                    q_full;
  logic                                    q_empty;
  kind_t                                   f_kind;
  logic [SLOT_W-1:0]                       f_slot;
  logic [NUM_VALS-1:0][COORD_WIDTH-1:0]    f_vals;
  logic [QW-1:0]                           q_wdata;
  logic [QW-1:0]                           q_rdata;
  kind_t                                   b_kind;
  logic [SLOT_W-1:0]                       b_slot;
  logic [NUM_VALS-1:0][COORD_WIDTH-1:0]    b_vals;

  // The front end classifies the request and trims each value to the
  // working width; it never pushes while the queue is full.
  fbc_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .push   (push),
    .q_full (q_full),
    .op     (op),
    .slot   (slot),
    .coef_a (coef_a),
    .coef_b (coef_b),
    .coef_c (coef_c),
    .coef_d (coef_d),
    .min_x  (min_x),
    .min_y  (min_y),
    .min_z  (min_z),
    .max_x  (max_x),
    .max_y  (max_y),
    .max_z  (max_z),
    .q_push (q_push),
    .q_kind (f_kind),
    .q_slot (f_slot),
    .q_vals (f_vals)
  );

  assign q_wdata = {f_kind, f_slot, f_vals};
  assign full    = q_full;

  fbc_fifo #(
    .DW(QW)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .rd    (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign b_kind = kind_t'(q_rdata[QW-1 -: 2]);
  assign b_slot = q_rdata[QW-3 -: SLOT_W];
  assign b_vals = q_rdata[NUM_VALS*COORD_WIDTH-1:0];

  // The back end owns the plane and corner stores, so loads and tests take
  // effect strictly in arrival order.
  fbc_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_kind  (b_kind),
    .q_slot  (b_slot),
    .q_vals  (b_vals),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .visible (visible)
  );

  // The front end must never push into a full queue.
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  // The back end must never pop an empty queue.
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // After reset no result is pending and requests are welcome.
  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("state not clean after reset");

endmodule
`default_nettype wire

[hdl/fbc_front.sv]
`default_nettype none
module fbc_front #(
  parameter int COORD_WIDTH = fbc_pkg::DEF_COORD_W
) (
  input  wire logic                                             push,
  input  wire logic                                             q_full,
  input  wire logic [fbc_pkg::OP_W-1:0]                         op,
  input  wire logic [fbc_pkg::SLOT_W-1:0]                       slot,
  input  wire logic [fbc_pkg::FIELD_W-1:0]                      coef_a,
  input  wire logic [fbc_pkg::FIELD_W-1:0]                      coef_b,
  input  wire logic [fbc_pkg::FIELD_W-1:0]                      coef_c,
  input  wire logic [fbc_pkg::FIELD_W-1:0]                      coef_d,
  input  wire logic [fbc_pkg::FIELD_W-1:0]                      min_x,
  input  wire logic [fbc_pkg::FIELD_W-1:0]                      min_y,
  input  wire logic [fbc_pkg::FIELD_W-1:0]                      min_z,
  input  wire logic [fbc_pkg::FIELD_W-1:0]                      max_x,
  input  wire logic [fbc_pkg::FIELD_W-1:0]                      max_y,
  input  wire logic [fbc_pkg::FIELD_W-1:0]                      max_z,
  output logic                                                  q_push,
  output fbc_pkg::kind_t                                        q_kind,
  output logic [fbc_pkg::SLOT_W-1:0]                            q_slot,
  output logic [fbc_pkg::NUM_VALS-1:0][COORD_WIDTH-1:0]         q_vals
);
  import fbc_pkg::*;

  logic keep;

  // Sort the request and drop those that change nothing.
  always_comb begin
    keep   = 1'b0;
    q_kind = K_TEST;
    case (op)
      OP_PLANE: begin
        keep   = ({1'b0, slot} < (SLOT_W+1)'(NUM_PLANES));
        q_kind = K_PLANE;
      end
      OP_CORNER: begin
        keep   = 1'b1;
        q_kind = K_CORNER;
      end
      OP_TEST: begin
        keep   = 1'b1;
        q_kind = K_TEST;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (q_kind == K_TEST) begin
      q_vals[0] = min_x[COORD_WIDTH-1:0];
      q_vals[1] = min_y[COORD_WIDTH-1:0];
      q_vals[2] = min_z[COORD_WIDTH-1:0];
      q_vals[3] = max_x[COORD_WIDTH-1:0];
      q_vals[4] = max_y[COORD_WIDTH-1:0];
      q_vals[5] = max_z[COORD_WIDTH-1:0];
    end else begin
      q_vals[0] = coef_a[COORD_WIDTH-1:0];
      q_vals[1] = coef_b[COORD_WIDTH-1:0];
      q_vals[2] = coef_c[COORD_WIDTH-1:0];
      q_vals[3] = coef_d[COORD_WIDTH-1:0];
      q_vals[4] = '0;
      q_vals[5] = '0;
    end
  end

  assign q_slot = slot;
  assign q_push = push && !q_full && keep;

endmodule
`default_nettype wire

[hdl/fbc_fifo.sv]
`default_nettype none
module fbc_fifo #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          rd,
  output logic [DW-1:0]      rdata,
  output logic               full,
  output logic               empty
);
  import fbc_pkg::*;

  logic [DW-1:0] mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  assign rdata = mem[rptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

endmodule
`default_nettype wire

[hdl/fbc_back.sv]
`default_nettype none
module fbc_back #(
  parameter int COORD_WIDTH = fbc_pkg::DEF_COORD_W,
  parameter int FRAC_BITS   = fbc_pkg::DEF_FRAC_W
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          q_empty,
  input  wire fbc_pkg::kind_t                                q_kind,
  input  wire logic [fbc_pkg::SLOT_W-1:0]                    q_slot,
  input  wire logic [fbc_pkg::NUM_VALS-1:0][COORD_WIDTH-1:0] q_vals,
  output logic                                               q_pop,
  input  wire logic                                          pop,
  output logic                                               empty,
  output logic                                               visible
);
  import fbc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int PW = $clog2(NUM_PLANES);
  localparam int CW = $clog2(NUM_CORNERS);
  localparam int DW = W + FRAC_BITS;
  localparam int SW = ((2 * W > DW) ? 2 * W : DW) + 2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PLANE = 4'b0010,
    S_CORN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  logic [PW-1:0] cnt;
  logic [1:0]    axis;

  logic signed [W-1:0] pa [NUM_PLANES];
  logic signed [W-1:0] pb [NUM_PLANES];
  logic signed [W-1:0] pc [NUM_PLANES];
  logic signed [W-1:0] pd [NUM_PLANES];
  logic signed [W-1:0] cx [NUM_CORNERS];
  logic signed [W-1:0] cy [NUM_CORNERS];
  logic signed [W-1:0] cz [NUM_CORNERS];
  logic signed [W-1:0] lo [3];
  logic signed [W-1:0] hi [3];

  logic                  a_valid;
  logic signed [2*W-1:0] pr0;
  logic signed [2*W-1:0] pr1;
  logic signed [2*W-1:0] pr2;
  logic signed [DW-1:0]  dterm;
  logic                  culled;
  logic                  out_valid;

  logic signed [W-1:0]  sx, sy, sz;
  logic signed [SW-1:0] sum;
  logic                 above, below;
  logic signed [W-1:0]  cv [NUM_CORNERS];
  logic signed [W-1:0]  alo, ahi;
  logic                 start;

  // Corner of the box that gives the largest value for this plane.
  always_comb begin
    sx = ((!pa[cnt][W-1]) == (hi[0] >= lo[0])) ? hi[0] : lo[0];
    sy = ((!pb[cnt][W-1]) == (hi[1] >= lo[1])) ? hi[1] : lo[1];
    sz = ((!pc[cnt][W-1]) == (hi[2] >= lo[2])) ? hi[2] : lo[2];
  end

  always_ff @(posedge clk) begin
    pr0   <= pa[cnt] * sx;
    pr1   <= pb[cnt] * sy;
    pr2   <= pc[cnt] * sz;
    dterm <= $signed({pd[cnt], {FRAC_BITS{1'b0}}});
  end

  assign sum = SW'(pr0) + SW'(pr1) + SW'(pr2) + SW'(dterm);

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      case (axis)
        2'd0:    cv[k] = cx[k];
        2'd1:    cv[k] = cy[k];
        default: cv[k] = cz[k];
      endcase
    end
    case (axis)
      2'd0:    begin alo = lo[0]; ahi = hi[0]; end
      2'd1:    begin alo = lo[1]; ahi = hi[1]; end
      default: begin alo = lo[2]; ahi = hi[2]; end
    endcase
    above = 1'b1;
    below = 1'b1;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      above = above && (cv[k] > ahi);
      below = below && (cv[k] < alo);
    end
  end

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign start = q_pop && (q_kind == K_TEST);

  always_ff @(posedge clk) begin
    if (q_pop && (q_kind == K_PLANE)) begin
      pa[q_slot[PW-1:0]] <= q_vals[0];
      pb[q_slot[PW-1:0]] <= q_vals[1];
      pc[q_slot[PW-1:0]] <= q_vals[2];
      pd[q_slot[PW-1:0]] <= q_vals[3];
    end
    if (q_pop && (q_kind == K_CORNER)) begin
      cx[q_slot[CW-1:0]] <= q_vals[0];
      cy[q_slot[CW-1:0]] <= q_vals[1];
      cz[q_slot[CW-1:0]] <= q_vals[2];
    end
    if (start) begin
      lo[0] <= q_vals[0];
      lo[1] <= q_vals[1];
      lo[2] <= q_vals[2];
      hi[0] <= q_vals[3];
      hi[1] <= q_vals[4];
      hi[2] <= q_vals[5];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      axis      <= 2'd0;
      a_valid   <= 1'b0;
      culled    <= 1'b0;
      out_valid <= 1'b0;
      visible   <= 1'b0;
    end else begin
      a_valid <= (state == S_PLANE);
      if (start) begin
        culled <= 1'b0;
      end else if ((a_valid && sum[SW-1]) || ((state == S_CORN) && (above || below))) begin
        culled <= 1'b1;
      end
      if ((state == S_DONE) && (!out_valid || pop)) begin
        out_valid <= 1'b1;
        visible   <= !culled;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cnt   <= '0;
            state <= S_PLANE;
          end
        end
        S_PLANE: begin
          if (cnt == PW'(NUM_PLANES - 1)) begin
            cnt   <= '0;
            axis  <= 2'd0;
            state <= S_CORN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_CORN: begin
          axis <= axis + 2'd1;
          if (axis == 2'd2) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign empty = !out_valid;

endmodule
`default_nettype wire
